@@ hdl/mfwb_pkg.sv @@
package mfwb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BASELINE_W = 20;
  localparam int FRAC_BITS  = 4;
  localparam int WLEN_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [BASELINE_W-1:0] baseline_t;
  typedef logic [WLEN_W-1:0]            wlen_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  // Register indexes on the configuration channel
  localparam cfg_idx_t REG_WINDOW_LEN     = 1'd0;
  localparam cfg_idx_t REG_MASK_THRESHOLD = 1'd1;

  localparam wlen_t   WLEN_RESET = 6'd16;
  localparam sample_t THR_RESET  = -16'sd40;

endpackage

@@ hdl/mfwb_in_if.sv @@
interface mfwb_in_if;
  import mfwb_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    end_of_waveform;

  modport source (output valid, sample, end_of_waveform, input ready);
  modport sink (input valid, sample, end_of_waveform, output ready);
endinterface

@@ hdl/mfwb_out_if.sv @@
interface mfwb_out_if;
  import mfwb_pkg::*;

  logic      valid;
  logic      ready;
  baseline_t baseline;
  logic      final_result;

  modport source (output valid, baseline, final_result, input ready);
  modport sink (input valid, baseline, final_result, output ready);
endinterface

@@ hdl/mfwb_cfg_if.sv @@
interface mfwb_cfg_if;
  import mfwb_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/mfwb_ring.sv @@
module mfwb_ring #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/mfwb_div.sv @@
module mfwb_div #(
  parameter int DVD_W = 25,
  parameter int DVS_W = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // One quotient bit per cycle, restoring on magnitudes
  assign rem_sh = {rem, q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DVD_W-1];
      q   <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DVS_W'(rem_sh - {1'b0, dvs});
        q   <= {q[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVS_W-1:0];
        q   <= {q[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Truncation toward zero: negate the magnitude quotient back
  assign quotient = neg ? -signed'(q) : signed'(q);

endmodule

@@ hdl/masked_forward_window_baseline.sv @@
// Masked forward-window baseline. Each incoming signed sample is masked
// (kept when strictly below mask_threshold, else taken as zero) and pushed
// into a sample ring held in a single synchronous memory. Baseline i is the
// mean of masked samples i..i+W-1 (or i..last near the end of a waveform),
// truncated toward zero, with 4 fractional bits. A baseline is sent as
// soon as its window is full; the request carrying end_of_waveform flushes
// the shrinking tail windows, the last one flagged by final_result, so a
// waveform of n samples gives exactly n baselines. Window lengths of 0 act
// as 1, lengths above WINDOW_MAX act as WINDOW_MAX.
// Timing: one request is worked on at a time. A request that yields no
// baseline passes S_CHECK and returns to S_IDLE. Each baseline waits on
// the shared divider, which retires one quotient bit per cycle and
// dominates. When the window was shortened mid-waveform, the oldest W
// samples are re-summed from the ring memory at one read per cycle. A new
// request is taken while the previous baseline still waits at the output
// register. Configuration writes are always taken (cfg.ready is tied high)
// and must only be issued while the block is idle.
module masked_forward_window_baseline #(
  parameter int WINDOW_MAX = 32
) (
  input logic    clk,
  input logic    rst,
  mfwb_in_if.sink      samples,
  mfwb_out_if.source   results,
  mfwb_cfg_if.sink     cfg
);
  import mfwb_pkg::*;

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int DVD_W = SUM_W + FRAC_BITS;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // Configuration registers
  wlen_t   window_len;
  sample_t mask_threshold;

  // Block state
  logic [2:0]              state;
  logic [PTR_W-1:0]        wp;
  logic [CNT_W-1:0]        fill;
  logic signed [SUM_W-1:0] sum;
  logic                    last_flag;
  logic [CNT_W-1:0]        w_cur;

  // Per-baseline working registers
  logic [CNT_W-1:0]        k;
  logic                    use_sum;
  logic [CNT_W-1:0]        need;
  logic [CNT_W-1:0]        issued;
  logic [CNT_W-1:0]        recv;
  logic [PTR_W-1:0]        rd_ptr;
  logic                    rd_pend;
  logic signed [SUM_W-1:0] acc;
  sample_t                 oldest_val;

  // Output register
  logic      out_valid;
  baseline_t out_baseline;
  logic      out_final;

  // Memory and divider hookups
  logic                    accept;
  sample_t                 masked;
  logic                    rd_en;
  logic [SAMPLE_W-1:0]     rd_data;
  sample_t                 rd_sample;
  logic                    div_start;
  logic signed [DVD_W-1:0] div_dividend;
  logic                    div_done;
  logic signed [DVD_W-1:0] div_quot;

  logic [CNT_W-1:0]        w_eff;
  logic [PTR_W-1:0]        oldest;
  logic [CNT_W:0]          wp_x;
  logic [CNT_W:0]          fill_x;
  logic [WLEN_W:0]         wl_x;
  logic                    out_free;
  logic                    out_load;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && (state == S_IDLE);

  // Mask: keep only samples strictly below the threshold
  assign masked = (samples.sample < mask_threshold) ? samples.sample : '0;

  // Clamp the configured window into 1..WINDOW_MAX
  always_comb begin
    wl_x = {1'b0, window_len};
    if (window_len == '0) begin
      w_eff = CNT_W'(1);
    end else if (wl_x > (WLEN_W + 1)'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(wl_x);
    end
  end

  // Oldest held slot: write pointer minus fill, modulo the ring depth
  always_comb begin
    wp_x   = (CNT_W + 1)'(wp);
    fill_x = (CNT_W + 1)'(fill);
    if (wp_x >= fill_x) begin
      oldest = PTR_W'(wp_x - fill_x);
    end else begin
      oldest = PTR_W'(wp_x + (CNT_W + 1)'(WINDOW_MAX) - fill_x);
    end
  end

  assign rd_en        = (state == S_READ) && (issued < need);
  assign rd_sample    = signed'(rd_data);
  assign div_start    = (state == S_DSTART);
  assign div_dividend = {(use_sum ? sum : acc), {FRAC_BITS{1'b0}}};
  assign out_free     = !out_valid || results.ready;
  assign out_load     = (state == S_OUT) && out_free;

  mfwb_ring #(
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (PTR_W),
    .DATA_W (SAMPLE_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wp),
    .wr_data (masked),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  mfwb_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (k),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= WLEN_RESET;
      mask_threshold <= THR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW_LEN:     window_len     <= cfg.data[WLEN_W-1:0];
        REG_MASK_THRESHOLD: mask_threshold <= signed'(cfg.data);
      endcase
    end
  end

  // Sequencer: push the request, then emit and drop while windows are full, or flush the tail at end of waveform
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      sum       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      // Load a new baseline, or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wp        <= (wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp + 1'b1;
            fill      <= fill + 1'b1;
            sum       <= sum + SUM_W'(masked);
            last_flag <= samples.end_of_waveform;
            w_cur     <= w_eff;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Pick the next window length, or finish this request
          issued <= '0;
          recv   <= '0;
          acc    <= '0;
          rd_ptr <= oldest;
          if (!last_flag) begin
            if (fill >= w_cur) begin
              k       <= w_cur;
              use_sum <= (w_cur == fill);
              need    <= (w_cur == fill) ? CNT_W'(1) : w_cur;
              state   <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end else if (fill != '0) begin
            k       <= (fill < w_cur) ? fill : w_cur;
            use_sum <= (fill <= w_cur);
            need    <= (fill <= w_cur) ? CNT_W'(1) : w_cur;
            state   <= S_READ;
          end else begin
            sum   <= '0;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          // Stream reads from the oldest slot; the first one is the sample to drop
          if (rd_en) begin
            issued <= issued + 1'b1;
            rd_ptr <= (rd_ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : rd_ptr + 1'b1;
          end
          if (rd_pend) begin
            acc  <= acc + SUM_W'(rd_sample);
            recv <= recv + 1'b1;
            if (recv == '0) begin
              oldest_val <= rd_sample;
            end
            if (recv + 1'b1 == need) begin
              state <= S_DSTART;
            end
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register frees up, then send and drop oldest
          if (out_free) begin
            out_baseline <= div_quot[BASELINE_W-1:0];
            out_final    <= last_flag && (fill == CNT_W'(1));
            sum          <= sum - SUM_W'(oldest_val);
            fill         <= fill - 1'b1;
            state        <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.baseline     = out_baseline;
  assign results.final_result = out_final;

endmodule

@@ tb/masked_forward_window_baseline_test.sv @@
module masked_forward_window_baseline_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfwb_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int WINDOW_MAX      = 32;
  localparam int MAX_GAP         = 11;
  // Give a request that yields no baseline time to retire, with plenty of margin.
  localparam int IDLE_CYCLES     = 8;
  localparam int RANDOM_PHASES   = 13;
  localparam int ITEMS_PER_PHASE = 30;
  // Slowest run is roughly 410 baselines, each with a divide, a re-sum and a monitor stall,
  // plus sender gaps; allow several times that.
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef struct packed {
    sample_t sample;
    logic    end_of_waveform;
  } sample_req_t;

  typedef struct packed {
    baseline_t baseline;
    logic      final_result;
  } baseline_result_t;

  logic clk = 1'b0;
  logic rst;

  mfwb_in_if  samples_if ();
  mfwb_out_if results_if ();
  mfwb_cfg_if cfg_if ();

  masked_forward_window_baseline #(
    .WINDOW_MAX(WINDOW_MAX)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .results(results_if),
    .cfg    (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Requests waiting for the driver, and baselines waiting for the monitor.
  sample_req_t      pending_samples[$];
  baseline_result_t expected_baselines[$];
  int               unsent_samples = 0;
  int               mismatch_count = 0;
  int unsigned      send_gap;
  int unsigned      recv_stall;
  bit               quiet_traffic = 1'b0;

  // Shadow copy of the block: masked sample window and its registers.
  sample_t held_ring[WINDOW_MAX];
  int      held_sum   = 0;
  int      held_count = 0;
  int      wr_ptr     = 0;
  wlen_t   window_cfg    = WLEN_RESET;
  sample_t threshold_cfg = THR_RESET;

  // Mean of the oldest k held samples, scaled by 16 and truncated toward zero.
  function automatic baseline_t oldest_mean(int k);
    longint total;
    int     slot;
    if (k == held_count) begin
      total = held_sum;
    end else begin
      total = 0;
      slot  = (wr_ptr + WINDOW_MAX - held_count) % WINDOW_MAX;
      for (int j = 0; j < k; j++) begin
        total += held_ring[slot];
        slot = (slot + 1) % WINDOW_MAX;
      end
    end
    return baseline_t'((total * 16) / k);
  endfunction

  function automatic void drop_oldest();
    held_sum -= held_ring[(wr_ptr + WINDOW_MAX - held_count) % WINDOW_MAX];
    held_count--;
  endfunction

  function automatic void push_baseline(baseline_t value, logic last);
    baseline_result_t entry;
    entry.baseline     = value;
    entry.final_result = last;
    expected_baselines = {expected_baselines, entry};
  endfunction

  // Advance the shadow window by one accepted request and queue the baselines it releases.
  function automatic void predict_baselines(sample_t raw, logic last);
    sample_t   kept;
    int        w;
    int        k;
    baseline_t mean;
    w = (window_cfg == 0) ? 1 : (window_cfg > WINDOW_MAX) ? WINDOW_MAX : int'(window_cfg);
    kept = (raw < threshold_cfg) ? raw : sample_t'(0);
    held_ring[wr_ptr] = kept;
    wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
    held_count++;
    held_sum += kept;
    if (!last) begin
      // Emit every full window, oldest first; more than one when the window was shortened.
      while (held_count >= w) begin
        push_baseline(oldest_mean(w), 1'b0);
        drop_oldest();
      end
    end else begin
      // Flush the shrinking tail windows; the very last one is flagged.
      while (held_count > 0) begin
        k    = (held_count < w) ? held_count : w;
        mean = oldest_mean(k);
        drop_oldest();
        push_baseline(mean, held_count == 0);
      end
      held_sum = 0;
    end
  endfunction

  function automatic int unsigned draw_gap();
    if (quiet_traffic) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void queue_sample(int value, logic last);
    sample_req_t req;
    req.sample          = sample_t'(value);
    req.end_of_waveform = last;
    pending_samples = {pending_samples, req};
    unsent_samples++;
  endfunction

  // Mix of extremes, values around the threshold, kept negatives and full-range noise.
  function automatic int pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    v = int'(threshold_cfg) + int'($urandom_range(0, 6)) - 3;
      4, 5, 6: v = -int'($urandom_range(0, 32768));
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic wlen_t pick_window();
    case ($urandom_range(0, 9))
      0:       return wlen_t'(0);
      1:       return wlen_t'(1);
      2:       return wlen_t'(WINDOW_MAX);
      3:       return wlen_t'($urandom_range(WINDOW_MAX + 1, 63));
      default: return wlen_t'($urandom_range(2, WINDOW_MAX - 1));
    endcase
  endfunction

  function automatic sample_t pick_threshold();
    case ($urandom_range(0, 6))
      0:       return THR_RESET;
      1:       return sample_t'(32767);
      2:       return sample_t'(-32768);
      3, 4:    return sample_t'(int'($urandom_range(0, 400)) - 200);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      7, 8:    return $urandom_range(13, 40);
      9:       return $urandom_range(41, 70);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Write one register and mirror it into the shadow copy. Call only while the block is idle.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_WINDOW_LEN:     window_cfg = value[WLEN_W-1:0];
      REG_MASK_THRESHOLD: threshold_cfg = sample_t'(value);
      default: ;
    endcase
  endtask

  // Hold off until every request went in and every expected baseline came out,
  // then give a request that releases nothing time to retire.
  task automatic wait_idle();
    while (unsent_samples != 0 || expected_baselines.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present one request at a time, drawing a fresh gap after each one.
  always @(posedge clk) begin : sample_driver
    sample_req_t req;
    logic        launch;
    if (rst) begin
      samples_if.valid <= 1'b0;
      send_gap         <= 0;
    end else begin
      launch = 1'b0;
      if (samples_if.valid && samples_if.ready) begin
        predict_baselines(samples_if.sample, samples_if.end_of_waveform);
        unsent_samples--;
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (send_gap != 0) send_gap <= send_gap - 1;
        else if (pending_samples.size() != 0) launch = 1'b1;
      end
      if (launch) begin
        req = pending_samples.pop_front();
        samples_if.valid           <= 1'b1;
        samples_if.sample          <= req.sample;
        samples_if.end_of_waveform <= req.end_of_waveform;
        send_gap                   <= draw_gap();
      end else if (!samples_if.valid || samples_if.ready) begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each baseline against the oldest prediction, then stall at random.
  always @(posedge clk) begin : baseline_monitor
    baseline_result_t want;
    int unsigned      stall;
    if (rst) begin
      results_if.ready <= 1'b0;
      recv_stall       <= 0;
    end else begin
      stall = recv_stall;
      if (results_if.valid && results_if.ready) begin
        if (expected_baselines.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected baseline: expected none, got %0d final %0b",
                   $time, results_if.baseline, results_if.final_result);
        end else begin
          want = expected_baselines.pop_front();
          if (want.baseline !== results_if.baseline ||
              want.final_result !== results_if.final_result) begin
            mismatch_count++;
            $display("%0t: baseline mismatch: expected %0d final %0b, got %0d final %0b",
                     $time, want.baseline, want.final_result,
                     results_if.baseline, results_if.final_result);
          end
        end
        stall = draw_gap();
      end else if (stall != 0) begin
        stall--;
      end
      recv_stall       <= stall;
      results_if.ready <= (stall == 0);
    end
  end

  initial begin : stimulus
    int wave_left;
    // Drive every input to a known value before the first edge.
    rst                        = 1'b1;
    samples_if.valid           = 1'b0;
    samples_if.sample          = '0;
    samples_if.end_of_waveform = 1'b0;
    results_if.ready           = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.index               = REG_WINDOW_LEN;
    cfg_if.data                = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a waveform shorter than the window, and samples right at the
    // threshold (equal is dropped, one below is kept).
    queue_sample(-32768, 1'b0);
    queue_sample(-40, 1'b0);
    queue_sample(-41, 1'b1);
    wait_idle();

    // Shortest window with the highest threshold: every request releases one baseline.
    write_reg(REG_WINDOW_LEN, cfg_data_t'(1));
    write_reg(REG_MASK_THRESHOLD, cfg_data_t'(32767));
    queue_sample(32767, 1'b0);
    queue_sample(32766, 1'b0);
    queue_sample(-32768, 1'b1);
    wait_idle();

    // Window length zero acts as one; include a single-sample waveform.
    write_reg(REG_WINDOW_LEN, cfg_data_t'(0));
    queue_sample(-1, 1'b1);
    queue_sample(5, 1'b0);
    queue_sample(-5, 1'b1);
    wait_idle();

    // Oversized window clamps to the maximum; lowest threshold masks everything.
    write_reg(REG_WINDOW_LEN, cfg_data_t'(63));
    write_reg(REG_MASK_THRESHOLD, cfg_data_t'(sample_t'(-32768)));
    queue_sample(-32768, 1'b0);
    queue_sample(100, 1'b0);
    queue_sample(-1, 1'b1);
    wait_idle();

    // Shorten the window mid-waveform: the next request releases a burst of baselines.
    write_reg(REG_WINDOW_LEN, cfg_data_t'(8));
    write_reg(REG_MASK_THRESHOLD, cfg_data_t'(1));
    queue_sample(-32768, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(-32768, 1'b0);
    queue_sample(-20000, 1'b0);
    wait_idle();
    write_reg(REG_WINDOW_LEN, cfg_data_t'(2));
    queue_sample(-32768, 1'b0);
    queue_sample(-12345, 1'b1);
    wait_idle();

    // Random phases of well-formed waveforms. A waveform may straddle a phase, so the
    // settings often change mid-waveform. The sender holds between phases until all
    // expected baselines have come.
    wave_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet_traffic = (phase % 5 == 2);
      write_reg(REG_WINDOW_LEN, cfg_data_t'(pick_window()));
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_reg(REG_MASK_THRESHOLD, cfg_data_t'(pick_threshold()));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (wave_left == 0) wave_left = pick_length();
        wave_left--;
        queue_sample(pick_sample(), wave_left == 0);
      end
      wait_idle();
    end

    // Close any open waveform so every held window drains.
    if (wave_left != 0) queue_sample(pick_sample(), 1'b1);
    quiet_traffic = 1'b0;
    wait_idle();

    if (mismatch_count == 0 && expected_baselines.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
